// ===== sv/pveu_pkg.sv =====
// ----------------------------------------------------------------------------
// pveu_pkg: shared types and constants of the particle update unit
// Fixed point formats, payload structs, lane structs and opcode codes.
// ----------------------------------------------------------------------------
package pveu_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FRAC_BITS   = 16;
  // dividend magnitude |force| * 2^FRAC_BITS
  localparam int unsigned NUM_W       = DATA_W + FRAC_BITS;
  // unsigned step (as signed) times signed value
  localparam int unsigned PROD_W      = 2 * DATA_W + 1;
  localparam int unsigned SUM_W       = PROD_W + 1;
  localparam int unsigned N_LANES     = 3;
  // one quotient bit per divider stage
  localparam int unsigned DIV_STAGES  = NUM_W;
  // divider, accel clamp, kick mult, kick add, drift mult, drift add
  localparam int unsigned LANE_STAGES = DIV_STAGES + 5;

  localparam logic [DATA_W-1:0] TIME_STEP_RST = DATA_W'(655);

  localparam logic [1:0] OP_KICK_DRIFT = 2'd0;
  localparam logic [1:0] OP_KICK       = 2'd1;
  localparam logic [1:0] OP_EULER      = 2'd2;
  localparam logic [1:0] OP_NOP        = 2'd3;

  typedef logic signed [DATA_W-1:0] fix_t;

  localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]        opcode;
    fix_t              pos_x;
    fix_t              pos_y;
    fix_t              pos_z;
    fix_t              vel_x;
    fix_t              vel_y;
    fix_t              vel_z;
    fix_t              force_x;
    fix_t              force_y;
    fix_t              force_z;
    logic [DATA_W-1:0] particle_mass;
  } pveu_in_t;

  typedef struct packed {
    fix_t new_pos_x;
    fix_t new_pos_y;
    fix_t new_pos_z;
    fix_t new_vel_x;
    fix_t new_vel_y;
    fix_t new_vel_z;
    logic saturated;
    logic bad_mass;
  } pveu_out_t;

  // one axis of one particle
  typedef struct packed {
    logic [1:0] opcode;
    logic       bad_mass;
    fix_t       pos;
    fix_t       vel;
    fix_t       frc;
  } pveu_lane_in_t;

  typedef struct packed {
    logic bad_mass;
    logic saturated;
    fix_t pos;
    fix_t vel;
  } pveu_lane_out_t;

endpackage

// ===== sv/particle_verlet_euler_update_unit.sv =====
// ----------------------------------------------------------------------------
// particle_verlet_euler_update_unit: velocity Verlet / Euler particle update
// Three axis lanes in parallel, flags merged into one registered result.
// ----------------------------------------------------------------------------
// The unit takes one particle per clock cycle while in_ready_o is high and
// returns one result per particle, in order, once it has passed through all
// the lane stages and the output register. The pipeline depth is set by
// the restoring divider in each axis lane, which forms the acceleration one
// quotient bit per stage (DATA_W + FRAC_BITS stages), followed by the
// acceleration clamp, the kick multiply, the velocity add, the drift multiply
// and the position add. The three lanes share one stall signal. A two-entry
// output buffer (output register plus skid register) lets the pipeline take
// one more particle while a result waits; in_ready_o drops only when both are
// full and comes back the cycle after the next output transfer. The time step
// register resets to 655 (about 0.01 in Q16.16) and must only be written
// while no particle is in flight; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module particle_verlet_euler_update_unit import pveu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DATA_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pveu_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pveu_out_t         out_data_o
);

  logic [DATA_W-1:0]      time_step_q;
  logic [LANE_STAGES-1:0] vld_q;
  logic                   out_valid_q, skid_valid_q;
  pveu_out_t              out_q, skid_q;
  pveu_out_t              merged;
  logic                   pipe_en;
  logic                   out_xfer;
  logic                   pipe_out;
  logic                   mass_zero;
  pveu_lane_in_t          lane_in  [N_LANES];
  pveu_lane_out_t         lane_out [N_LANES];

  // time step register, writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RST;
    end else if (cfg_valid_i) begin
      time_step_q <= cfg_data_i;
    end
  end

  // whole datapath moves together unless the skid register is occupied
  assign pipe_en    = ~skid_valid_q;
  assign in_ready_o = pipe_en;
  assign out_xfer   = out_valid_q & out_ready_i;
  assign pipe_out   = pipe_en & vld_q[LANE_STAGES-1];

  // a NOP never flags the mass
  assign mass_zero = (in_data_i.particle_mass == '0) && (in_data_i.opcode != OP_NOP);

  always_comb begin
    lane_in[0] = '{opcode: in_data_i.opcode, bad_mass: mass_zero, pos: in_data_i.pos_x,
                   vel: in_data_i.vel_x, frc: in_data_i.force_x};
    lane_in[1] = '{opcode: in_data_i.opcode, bad_mass: mass_zero, pos: in_data_i.pos_y,
                   vel: in_data_i.vel_y, frc: in_data_i.force_y};
    lane_in[2] = '{opcode: in_data_i.opcode, bad_mass: mass_zero, pos: in_data_i.pos_z,
                   vel: in_data_i.vel_z, frc: in_data_i.force_z};
  end

  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    pveu_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (pipe_en),
      .lane_i      (lane_in[l]),
      .mass_i      (in_data_i.particle_mass),
      .time_step_i (time_step_q),
      .lane_o      (lane_out[l])
    );
  end

  // merge: any clamp in any lane raises the flag
  always_comb begin
    logic sat_any;
    sat_any = 1'b0;
    for (int l = 0; l < N_LANES; l++) begin
      sat_any = sat_any | lane_out[l].saturated;
    end
    merged.new_pos_x = lane_out[0].pos;
    merged.new_pos_y = lane_out[1].pos;
    merged.new_pos_z = lane_out[2].pos;
    merged.new_vel_x = lane_out[0].vel;
    merged.new_vel_y = lane_out[1].vel;
    merged.new_vel_z = lane_out[2].vel;
    merged.saturated = sat_any;
    merged.bad_mass  = lane_out[0].bad_mass;
  end

  // valid bits of the lane stages and of the output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pipe_en) begin
        vld_q <= {vld_q[LANE_STAGES-2:0], in_valid_i};
      end
      if (skid_valid_q) begin
        // drain the skid entry into the output register
        if (out_xfer) begin
          skid_valid_q <= 1'b0;
        end
      end else if (pipe_out) begin
        if (!out_valid_q || out_xfer) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (pipe_out) begin
      if (!out_valid_q || out_xfer) begin
        out_q <= merged;
      end else begin
        skid_q <= merged;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/pveu_div.sv =====
// ----------------------------------------------------------------------------
// pveu_div: pipelined restoring divider
// Divides |force| * 2^FRAC_BITS by the mass, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pveu_div import pveu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  fix_t              force_i,
  input  logic [DATA_W-1:0] mass_i,
  output logic [NUM_W-1:0]  quot_o,
  output logic              neg_o
);

  logic [DATA_W-1:0] rem_q   [DIV_STAGES-1];
  logic [NUM_W-1:0]  num_q   [DIV_STAGES];
  logic [DATA_W-1:0] mass_q  [DIV_STAGES-1];
  logic              neg_q   [DIV_STAGES];

  logic [DATA_W-1:0] rem_src  [DIV_STAGES];
  logic [NUM_W-1:0]  num_src  [DIV_STAGES];
  logic [DATA_W-1:0] mass_src [DIV_STAGES];
  logic [DATA_W+1:0] diff     [DIV_STAGES];
  logic [DATA_W-1:0] frc_mag;

  assign frc_mag = force_i[DATA_W-1] ? $unsigned(-force_i) : $unsigned(force_i);

  always_comb begin
    rem_src[0]  = '0;
    num_src[0]  = {frc_mag, {FRAC_BITS{1'b0}}};
    mass_src[0] = mass_i;
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_src[k]  = rem_q[k-1];
      num_src[k]  = num_q[k-1];
      mass_src[k] = mass_q[k-1];
    end
    // trial subtract, borrow in the top bit means the bit is zero
    for (int k = 0; k < DIV_STAGES; k++) begin
      diff[k] = {1'b0, rem_src[k], num_src[k][NUM_W-1]} - {2'b00, mass_src[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        num_q[k] <= {num_src[k][NUM_W-2:0], ~diff[k][DATA_W+1]};
      end
      for (int k = 0; k < DIV_STAGES - 1; k++) begin
        rem_q[k]  <= diff[k][DATA_W+1] ? {rem_src[k][DATA_W-2:0], num_src[k][NUM_W-1]}
                                       : diff[k][DATA_W-1:0];
        mass_q[k] <= mass_src[k];
      end
      neg_q[0] <= force_i[DATA_W-1];
      for (int k = 1; k < DIV_STAGES; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign quot_o = num_q[DIV_STAGES-1];
  assign neg_o  = neg_q[DIV_STAGES-1];

endmodule

// ===== sv/pveu_lane.sv =====
// ----------------------------------------------------------------------------
// pveu_lane: one axis of the integrator
// Acceleration by division, kick, then drift, each with saturation.
// ----------------------------------------------------------------------------
module pveu_lane import pveu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  pveu_lane_in_t     lane_i,
  input  logic [DATA_W-1:0] mass_i,
  input  logic [DATA_W-1:0] time_step_i,
  output pveu_lane_out_t    lane_o
);

  typedef struct packed {
    logic [1:0] opcode;
    logic       bad;
    fix_t       pos;
    fix_t       vel;
  } side_t;

  typedef struct packed {
    side_t side;
    logic  sat;
    fix_t  acc;
  } acc_st_t;

  typedef struct packed {
    side_t                     side;
    logic                      sat;
    logic signed [PROD_W-1:0]  prod;
  } mul_st_t;

  typedef struct packed {
    side_t side;
    logic  sat;
  } add_st_t;

  typedef struct packed {
    logic ovf;
    fix_t val;
  } clamp_t;

  function automatic clamp_t clamp_sum(input logic signed [SUM_W-1:0] v);
    clamp_t r;
    r.ovf = (|v[SUM_W-1:DATA_W-1]) && !(&v[SUM_W-1:DATA_W-1]);
    if (!r.ovf) begin
      r.val = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      r.val = FIX_MIN;
    end else begin
      r.val = FIX_MAX;
    end
    return r;
  endfunction

  side_t   side_q [DIV_STAGES];
  acc_st_t acc_q,  acc_d;
  mul_st_t kmul_q, kmul_d;
  add_st_t kadd_q, kadd_d;
  mul_st_t dmul_q, dmul_d;
  add_st_t dadd_q, dadd_d;

  logic [NUM_W-1:0] quot;
  logic             quot_neg;

  pveu_div u_div (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .force_i (lane_i.frc),
    .mass_i  (mass_i),
    .quot_o  (quot),
    .neg_o   (quot_neg)
  );

  // acceleration: sign the quotient and clamp
  always_comb begin
    logic ovf;
    side_t s;
    s   = side_q[DIV_STAGES-1];
    ovf = quot_neg ? ((|quot[NUM_W-1:DATA_W]) || (quot[DATA_W-1] && |quot[DATA_W-2:0]))
                   : (|quot[NUM_W-1:DATA_W-1]);
    acc_d.side = s;
    if (s.bad || s.opcode == OP_NOP) begin
      acc_d.acc = '0;
      acc_d.sat = 1'b0;
    end else if (ovf) begin
      acc_d.acc = quot_neg ? FIX_MIN : FIX_MAX;
      acc_d.sat = 1'b1;
    end else begin
      acc_d.acc = quot_neg ? -$signed(quot[DATA_W-1:0]) : $signed(quot[DATA_W-1:0]);
      acc_d.sat = 1'b0;
    end
  end

  // kick product, full or half step
  always_comb begin
    logic [DATA_W-1:0]        h;
    logic signed [PROD_W-1:0] p;
    h = (acc_q.side.opcode == OP_EULER) ? time_step_i : (time_step_i >> 1);
    p = $signed({1'b0, h}) * acc_q.acc;
    kmul_d.side = acc_q.side;
    kmul_d.sat  = acc_q.sat;
    kmul_d.prod = p;
  end

  // velocity update, floor shift then saturating add
  always_comb begin
    logic signed [PROD_W-1:0] kick;
    logic signed [SUM_W-1:0]  vsum;
    clamp_t                   c;
    kick = kmul_q.prod >>> FRAC_BITS;
    vsum = {{(SUM_W-DATA_W){kmul_q.side.vel[DATA_W-1]}}, kmul_q.side.vel}
         + {kick[PROD_W-1], kick};
    c    = clamp_sum(vsum);
    kadd_d          = '{side: kmul_q.side, sat: kmul_q.sat | c.ovf};
    kadd_d.side.vel = c.val;
  end

  // drift product with the updated velocity
  always_comb begin
    logic signed [PROD_W-1:0] p;
    p = $signed({1'b0, time_step_i}) * kadd_q.side.vel;
    dmul_d.side = kadd_q.side;
    dmul_d.sat  = kadd_q.sat;
    dmul_d.prod = p;
  end

  // position update where the opcode drifts
  always_comb begin
    logic signed [PROD_W-1:0] drift;
    logic signed [SUM_W-1:0]  psum;
    clamp_t                   c;
    drift  = dmul_q.prod >>> FRAC_BITS;
    psum   = {{(SUM_W-DATA_W){dmul_q.side.pos[DATA_W-1]}}, dmul_q.side.pos}
           + {drift[PROD_W-1], drift};
    c      = clamp_sum(psum);
    dadd_d = '{side: dmul_q.side, sat: dmul_q.sat};
    if (dmul_q.side.opcode == OP_KICK_DRIFT || dmul_q.side.opcode == OP_EULER) begin
      dadd_d.side.pos = c.val;
      dadd_d.sat      = dmul_q.sat | c.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{opcode: lane_i.opcode, bad: lane_i.bad_mass,
                     pos: lane_i.pos, vel: lane_i.vel};
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
      acc_q  <= acc_d;
      kmul_q <= kmul_d;
      kadd_q <= kadd_d;
      dmul_q <= dmul_d;
      dadd_q <= dadd_d;
    end
  end

  assign lane_o = '{bad_mass: dadd_q.side.bad, saturated: dadd_q.sat,
                    pos: dadd_q.side.pos, vel: dadd_q.side.vel};

endmodule

// ===== sv/pveu_checker.sv =====
// ----------------------------------------------------------------------------
// pveu_checker: port level checks of the particle update unit
// Output stall behavior and input backpressure seen from the ports.
// ----------------------------------------------------------------------------
module pveu_checker import pveu_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pveu_out_t         out_data_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or vanished while stalled");

  // backpressure only after an output stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input blocked without an output stall");

  // input blocked means a result is waiting
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no result shown");

  // one output transfer frees the input side
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_ready_i |=> in_ready_o)
    else $error("input still blocked after an output transfer");

endmodule

bind particle_verlet_euler_update_unit pveu_checker u_pveu_checker (.*);
